@@ rtl/core/pcrlh_pkg.sv @@
// pcrlh_pkg: shared types, constants and codes of the per-channel run-length histogram unit
// no dependencies; imported by the interfaces and by every module under rtl/core but pcrlh_ram
package pcrlh_pkg;

  // default sizes of the storage
  localparam int NumMoleculesDef = 256;
  localparam int MaxBinsDef      = 1024;
  localparam int CountBitsDef    = 20;

  // fixed field widths
  localparam int MOL_W   = 8;
  localparam int SIZE_W  = 9;
  localparam int LEN_W   = 11;
  localparam int BCNT_W  = 20;
  localparam int CFG_W   = 11;
  localparam int CIDX_W  = 1;

  localparam logic [SIZE_W-1:0] MIN_CLUSTER_RST = 9'd1;
  localparam logic [LEN_W-1:0]  MAX_RUN_RST     = 11'd1000;
  localparam logic [LEN_W-1:0]  RUN_CNT_SAT     = {LEN_W{1'b1}};

  typedef enum logic [CIDX_W-1:0] {
    REG_MIN_CLUSTER = 1'b0,
    REG_MAX_RUN     = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } state_e;

  // pipeline control from the top level
  typedef struct packed {
    logic adv;  // all stages move on this cycle
    logic clr;  // clearing pass in progress
  } pipe_ctl_t;

  // run stage result handed to the bin stage
  typedef struct packed {
    logic [MOL_W-1:0] mol;
    logic             closed;
    logic [LEN_W-1:0] length;
  } run_res_t;

endpackage

@@ rtl/core/pcrlh_if.sv @@
// pcrlh_in_if and pcrlh_out_if: valid/ready channels of the run-length histogram unit
// depends on pcrlh_pkg for the field widths
interface pcrlh_in_if import pcrlh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MOL_W-1:0]  molecule_index;
  logic [SIZE_W-1:0] cluster_size;
  logic              end_of_record;

  modport source (output valid, molecule_index, cluster_size, end_of_record, input ready);
  modport sink   (input valid, molecule_index, cluster_size, end_of_record, output ready);
endinterface

interface pcrlh_out_if import pcrlh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MOL_W-1:0]  molecule_echo;
  logic              run_closed;
  logic [LEN_W-1:0]  run_length;
  logic [BCNT_W-1:0] bin_count;

  modport source (output valid, molecule_echo, run_closed, run_length, bin_count, input ready);
  modport sink   (input valid, molecule_echo, run_closed, run_length, bin_count, output ready);
endinterface

@@ rtl/core/pcrlh_ram.sv @@
// pcrlh_ram: generic single-write, single-read synchronous ram with registered read
// no dependencies; read during write to the same address returns the old data
module pcrlh_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/pcrlh_run_stage.sv @@
// pcrlh_run_stage: per-molecule run counter ram, its forwarding register and the close decision
// depends on pcrlh_pkg and pcrlh_ram
module pcrlh_run_stage import pcrlh_pkg::*; #(
  parameter int NumMolecules = NumMoleculesDef,
  parameter int MaxBins      = MaxBinsDef,
  parameter int HistAw       = 18
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pipe_ctl_t         ctl_i,
  input  logic [HistAw-1:0] clr_addr_i,
  input  logic              accept_i,
  input  logic [MOL_W-1:0]  mol_i,
  input  logic [SIZE_W-1:0] size_i,
  input  logic              eor_i,
  input  logic [SIZE_W-1:0] min_cluster_i,
  input  logic [LEN_W-1:0]  max_run_i,
  output logic              valid_o,
  output run_res_t          res_o,
  output logic [HistAw-1:0] hist_addr_o
);
  localparam int MOL_AW = (NumMolecules > 1) ? $clog2(NumMolecules) : 1;
  localparam int BIN_W  = $clog2(MaxBins);
  localparam int EW     = ($clog2(MaxBins + 1) > LEN_W) ? $clog2(MaxBins + 1) : LEN_W;

  // stage 0: address decode
  logic [MOL_AW+MOL_W-1:0] mol_ext;
  logic [MOL_AW-1:0]       mol_addr;
  logic                    in_range;
  logic                    extend;
  logic [HistAw-1:0]       base;

  assign mol_ext  = {{MOL_AW{1'b0}}, mol_i};
  assign mol_addr = mol_ext[MOL_AW-1:0];
  assign in_range = mol_ext < (MOL_AW + MOL_W)'(NumMolecules);
  assign extend   = !eor_i && (size_i >= min_cluster_i);
  assign base     = HistAw'(mol_addr) * HistAw'(MaxBins);

  // stage 1 registers
  logic              valid_q;
  logic [MOL_W-1:0]  mol_q;
  logic [MOL_AW-1:0] addr_q;
  logic              in_range_q;
  logic              extend_q;
  logic [HistAw-1:0] base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.adv) begin
      valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      mol_q      <= mol_i;
      addr_q     <= mol_addr;
      in_range_q <= in_range;
      extend_q   <= extend;
      base_q     <= base;
    end
  end

  // counter ram and forwarding of the write made at the read edge
  logic              fwd_valid_q;
  logic [MOL_AW-1:0] fwd_addr_q;
  logic [LEN_W-1:0]  fwd_data_q;
  logic [LEN_W-1:0]  ram_rdata;
  logic [LEN_W-1:0]  cnt;
  logic [LEN_W-1:0]  cnt_d;
  logic              wr_item;
  logic              ram_we;
  logic [MOL_AW-1:0] ram_waddr;
  logic [LEN_W-1:0]  ram_wdata;

  assign wr_item = ctl_i.adv && valid_q && in_range_q;
  assign cnt     = (fwd_valid_q && (fwd_addr_q == addr_q)) ? fwd_data_q : ram_rdata;

  always_comb begin
    if (ctl_i.clr) begin
      ram_we    = clr_addr_i < HistAw'(NumMolecules);
      ram_waddr = clr_addr_i[MOL_AW-1:0];
      ram_wdata = '0;
    end else begin
      ram_we    = wr_item;
      ram_waddr = addr_q;
      ram_wdata = cnt_d;
    end
  end

  pcrlh_ram #(
    .Width (LEN_W),
    .Depth (NumMolecules)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ctl_i.adv),
    .raddr_i (mol_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (ctl_i.adv) begin
      fwd_valid_q <= valid_q && in_range_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_item) begin
      fwd_addr_q <= addr_q;
      fwd_data_q <= cnt_d;
    end
  end

  // close decision and bin address
  logic [EW-1:0]    eff_max;
  logic [EW-1:0]    max_ext;
  logic [EW-1:0]    cnt_ext;
  logic [EW-1:0]    clamped;
  logic [BIN_W-1:0] bin;

  assign max_ext = EW'(max_run_i);
  assign cnt_ext = EW'(cnt);
  assign eff_max = (max_run_i == '0) ? EW'(1) :
                   ((max_ext > EW'(MaxBins)) ? EW'(MaxBins) : max_ext);
  assign clamped = (cnt_ext > eff_max) ? eff_max : cnt_ext;
  assign bin     = BIN_W'(clamped - EW'(1));

  always_comb begin
    res_o.mol    = mol_q;
    res_o.closed = 1'b0;
    res_o.length = '0;
    cnt_d        = cnt;
    if (in_range_q) begin
      if (extend_q) begin
        cnt_d        = (cnt == RUN_CNT_SAT) ? cnt : cnt + LEN_W'(1);
        res_o.length = cnt_d;
      end else begin
        cnt_d        = '0;
        res_o.closed = (cnt != '0);
        res_o.length = (cnt != '0) ? LEN_W'(clamped) : '0;
      end
    end
  end

  assign valid_o     = valid_q;
  assign hist_addr_o = base_q + HistAw'(bin);

endmodule

@@ rtl/core/pcrlh_bin_stage.sv @@
// pcrlh_bin_stage: histogram ram, its forwarding register and the saturating bin increment
// depends on pcrlh_pkg and pcrlh_ram
module pcrlh_bin_stage import pcrlh_pkg::*; #(
  parameter int HistDepth = 262144,
  parameter int HistAw    = 18,
  parameter int CountBits = CountBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pipe_ctl_t         ctl_i,
  input  logic [HistAw-1:0] clr_addr_i,
  input  logic              valid_i,
  input  run_res_t          res_i,
  input  logic [HistAw-1:0] hist_addr_i,
  output logic              valid_o,
  output run_res_t          res_o,
  output logic [BCNT_W-1:0] bin_count_o
);
  logic              valid_q;
  run_res_t          res_q;
  logic [HistAw-1:0] addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      res_q  <= res_i;
      addr_q <= hist_addr_i;
    end
  end

  logic                 fwd_valid_q;
  logic [HistAw-1:0]    fwd_addr_q;
  logic [CountBits-1:0] fwd_data_q;
  logic [CountBits-1:0] ram_rdata;
  logic [CountBits-1:0] cur;
  logic [CountBits-1:0] nxt;
  logic                 wr_item;
  logic                 ram_we;
  logic [HistAw-1:0]    ram_waddr;
  logic [CountBits-1:0] ram_wdata;

  assign wr_item = ctl_i.adv && valid_q && res_q.closed;
  assign cur     = (fwd_valid_q && (fwd_addr_q == addr_q)) ? fwd_data_q : ram_rdata;
  assign nxt     = (cur == {CountBits{1'b1}}) ? cur : cur + CountBits'(1);

  always_comb begin
    if (ctl_i.clr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_i;
      ram_wdata = '0;
    end else begin
      ram_we    = wr_item;
      ram_waddr = addr_q;
      ram_wdata = nxt;
    end
  end

  pcrlh_ram #(
    .Width (CountBits),
    .Depth (HistDepth)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ctl_i.adv),
    .raddr_i (hist_addr_i),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (ctl_i.adv) begin
      fwd_valid_q <= valid_q && res_q.closed;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_item) begin
      fwd_addr_q <= addr_q;
      fwd_data_q <= nxt;
    end
  end

  logic [CountBits+BCNT_W-1:0] nxt_ext;

  assign nxt_ext     = {{BCNT_W{1'b0}}, nxt};
  assign valid_o     = valid_q;
  assign res_o       = res_q;
  assign bin_count_o = res_q.closed ? nxt_ext[BCNT_W-1:0] : '0;

endmodule

@@ rtl/core/per_channel_run_length_histogram_unit.sv @@
// per_channel_run_length_histogram_unit: top level of the per-molecule run-length histogram
// depends on pcrlh_pkg, pcrlh_if, pcrlh_ram, pcrlh_run_stage and pcrlh_bin_stage
//
//  port        | dir | kind           | payload
//  ------------+-----+----------------+------------------------------------------------
//  sample_i    | in  | valid/ready    | molecule_index, cluster_size, end_of_record
//  result_o    | out | valid/ready    | molecule_echo, run_closed, run_length, bin_count
//  cfg_*_i     | in  | write enable   | cfg_idx_i selects register, cfg_wdata_i value
//
// one transaction per cycle sustained while results are taken; a sample goes from acceptance to
// result through the counter ram read, the histogram ram read and the output register
// both rams are read-modify-write with a forwarding register each, so the same molecule
// or bin on consecutive cycles needs no bubble
// after reset a clearing pass over all NumMolecules * MaxBins histogram addresses (262144 by
// default) zeroes the histogram and the counters; no sample is taken during it, configuration
// writes are taken throughout
// a stalled result freezes the pipeline only when the last stage is full; bubbles ahead of
// it still close up, so up to two samples can be taken behind a waiting result
module per_channel_run_length_histogram_unit import pcrlh_pkg::*; #(
  parameter int NumMolecules = NumMoleculesDef,
  parameter int MaxBins      = MaxBinsDef,
  parameter int CountBits    = CountBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pcrlh_in_if.sink          sample_i,
  pcrlh_out_if.source       result_o,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i
);
  localparam int HistDepth = NumMolecules * MaxBins;
  localparam int HistAw    = $clog2(HistDepth);

  // configuration registers
  logic [SIZE_W-1:0] min_cluster_q;
  logic [LEN_W-1:0]  max_run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_cluster_q <= MIN_CLUSTER_RST;
      max_run_q     <= MAX_RUN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIN_CLUSTER: min_cluster_q <= cfg_wdata_i[SIZE_W-1:0];
        REG_MAX_RUN:     max_run_q     <= cfg_wdata_i[LEN_W-1:0];
        default:         ;
      endcase
    end
  end

  // clearing pass state machine
  state_e            state_q, state_d;
  logic [HistAw-1:0] sweep_q, sweep_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      sweep_q <= '0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
    end
  end

  always_comb begin
    state_d = state_q;
    sweep_d = sweep_q;
    unique case (state_q)
      ST_CLEAR: begin
        sweep_d = sweep_q + HistAw'(1);
        if (sweep_q == HistAw'(HistDepth - 1)) begin
          state_d = ST_RUN;
          sweep_d = '0;
        end
      end
      ST_RUN: begin
        sweep_d = '0;
      end
      default: begin
        state_d = ST_CLEAR;
        sweep_d = '0;
      end
    endcase
  end

  // pipeline advance: stall only when a full last stage faces a waiting result
  pipe_ctl_t ctl;
  logic      s2_valid;
  logic      out_valid_q;
  logic      accept;

  assign ctl            = '{adv: !(out_valid_q && !result_o.ready && s2_valid),
                            clr: (state_q == ST_CLEAR)};
  assign sample_i.ready = !ctl.clr && ctl.adv;
  assign accept         = sample_i.valid && sample_i.ready;

  // stage 1: run counter
  logic              s1_valid;
  run_res_t          s1_res;
  logic [HistAw-1:0] s1_hist_addr;

  pcrlh_run_stage #(
    .NumMolecules (NumMolecules),
    .MaxBins      (MaxBins),
    .HistAw       (HistAw)
  ) u_run_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .clr_addr_i    (sweep_q),
    .accept_i      (accept),
    .mol_i         (sample_i.molecule_index),
    .size_i        (sample_i.cluster_size),
    .eor_i         (sample_i.end_of_record),
    .min_cluster_i (min_cluster_q),
    .max_run_i     (max_run_q),
    .valid_o       (s1_valid),
    .res_o         (s1_res),
    .hist_addr_o   (s1_hist_addr)
  );

  // stage 2: histogram bin
  run_res_t          s2_res;
  logic [BCNT_W-1:0] s2_bin_count;

  pcrlh_bin_stage #(
    .HistDepth (HistDepth),
    .HistAw    (HistAw),
    .CountBits (CountBits)
  ) u_bin_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .clr_addr_i  (sweep_q),
    .valid_i     (s1_valid),
    .res_i       (s1_res),
    .hist_addr_i (s1_hist_addr),
    .valid_o     (s2_valid),
    .res_o       (s2_res),
    .bin_count_o (s2_bin_count)
  );

  // output register
  logic              out_valid_d;
  run_res_t          out_res_q;
  logic [BCNT_W-1:0] out_bin_count_q;
  logic              out_load;

  assign out_load = ctl.adv && s2_valid;

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_res_q       <= s2_res;
      out_bin_count_q <= s2_bin_count;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.molecule_echo = out_res_q.mol;
  assign result_o.run_closed    = out_res_q.closed;
  assign result_o.run_length    = out_res_q.length;
  assign result_o.bin_count     = out_bin_count_q;

  // no sample enters while the rams are being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.clr |-> !sample_i.ready)
    else $error("sample taken during clearing pass");

  // a closed run always has a non-zero length and a non-zero bin count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.closed) |->
      (out_res_q.length != '0) && (out_bin_count_q != '0))
    else $error("closed run with empty length or count");

  // an open run reports no bin count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_res_q.closed) |-> (out_bin_count_q == '0))
    else $error("bin count on a result without a closed run");

  // a waiting result with a full last stage holds the whole pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_o.ready && s2_valid) |=> (s2_valid && out_valid_q))
    else $error("stalled stage lost its transaction");

endmodule

@@ tb/testbench.sv @@
// testbench for per_channel_run_length_histogram_unit: directed and random samples,
// predicted per molecule run counters and histogram bins, checked per result transaction
// depends on pcrlh_pkg, pcrlh_in_if, pcrlh_out_if and the unit itself
module testbench;
  import pcrlh_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // nothing is accepted during the clearing pass after reset
  localparam int unsigned QuietLimit = 1000000;
  localparam int unsigned CountMax   = (1 << CountBitsDef) - 1;
  localparam int          LongHold   = 300;

  typedef struct packed {
    logic [MOL_W-1:0]  mol;
    logic [SIZE_W-1:0] size;
    logic              eor;
  } sample_t;

  typedef struct packed {
    logic [MOL_W-1:0]  mol;
    logic              closed;
    logic [LEN_W-1:0]  len;
    logic [BCNT_W-1:0] count;
  } outcome_t;

  logic clk_i;
  logic rst_ni;
  logic              cfg_we;
  logic [CIDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]  cfg_wdata;

  pcrlh_in_if  sample_if ();
  pcrlh_out_if result_if ();

  per_channel_run_length_histogram_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_if),
    .result_o    (result_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // shadow of the unit: configuration, run counters and histogram bins
  logic [SIZE_W-1:0]  min_size_q = MIN_CLUSTER_RST;
  logic [LEN_W-1:0]   max_run_q  = MAX_RUN_RST;
  logic [LEN_W-1:0]   run_count [NumMoleculesDef];
  int unsigned        bin_tally [int unsigned];

  sample_t  pending_samples[$];
  outcome_t expected_outcomes[$];
  sample_t  held_sample;
  logic     sample_busy = 1'b0;

  // traffic shaping, set per phase by the sequencer
  logic bursty_send = 1'b0;
  logic bursty_take = 1'b0;
  logic calm        = 1'b0;
  int   hold_token  = 0;

  // statistics and errors
  int unsigned errors         = 0;
  int unsigned samples_taken  = 0;
  int unsigned results_seen   = 0;
  int unsigned closed_seen    = 0;
  int unsigned clamped_runs   = 0;
  int unsigned saturated_hits = 0;
  int unsigned quiet_cycles   = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // next state of one molecule for an accepted sample, and the result it gives
  function automatic outcome_t advance_run(sample_t s);
    outcome_t         r;
    logic [LEN_W-1:0] cnt;
    logic [LEN_W-1:0] top;
    logic [LEN_W-1:0] len;
    int unsigned      key;
    int unsigned      c;
    r = '{mol: s.mol, closed: 1'b0, len: '0, count: '0};
    // an 8 bit index never exceeds the 256 molecules, so every sample is handled
    cnt = run_count[s.mol];
    if (!s.eor && s.size >= min_size_q) begin
      // still inside an aggregate: extend, holding at the counter ceiling
      if (cnt != RUN_CNT_SAT) begin
        cnt = cnt + 1'b1;
      end else begin
        saturated_hits++;
      end
      run_count[s.mol] = cnt;
      r.len = cnt;
    end else begin
      if (cnt != '0) begin
        // effective maximum: 0 acts as 1, anything above the bin count as the last bin
        if (max_run_q == '0) begin
          top = LEN_W'(1);
        end else if (max_run_q > MaxBinsDef) begin
          top = LEN_W'(MaxBinsDef);
        end else begin
          top = max_run_q;
        end
        if (cnt > top) begin
          len = top;
          clamped_runs++;
        end else begin
          len = cnt;
        end
        key = s.mol * MaxBinsDef + len - 1;
        c = bin_tally.exists(key) ? bin_tally[key] : 0;
        if (c != CountMax) c++;
        bin_tally[key] = c;
        r.closed = 1'b1;
        r.len    = len;
        r.count  = c[BCNT_W-1:0];
      end
      run_count[s.mol] = '0;
    end
    return r;
  endfunction

  function automatic void log_error(string msg);
    if (errors < 10) $display("%s", msg);
    errors++;
  endfunction

  // driver: offers pending samples, with random gaps when the phase allows them
  int send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (sample_if.valid && sample_if.ready) begin
        samples_taken++;
        expected_outcomes.push_back(advance_run(held_sample));
        sample_busy = 1'b0;
      end
      // the offered sample may only change once it has been taken
      if (!sample_if.valid || sample_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          sample_if.valid <= 1'b0;
        end else if (pending_samples.size() == 0) begin
          sample_if.valid <= 1'b0;
        end else if (bursty_send && !calm && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 15);
          sample_if.valid <= 1'b0;
        end else begin
          held_sample = pending_samples.pop_front();
          sample_busy = 1'b1;
          sample_if.molecule_index <= held_sample.mol;
          sample_if.cluster_size   <= held_sample.size;
          sample_if.end_of_record  <= held_sample.eor;
          sample_if.valid          <= 1'b1;
        end
      end
    end
  end

  // monitor: checks each result transaction and shapes ready
  int take_gap  = 0;
  int hold_left = 0;
  int hold_seen = 0;
  always @(posedge clk_i) begin
    outcome_t got;
    outcome_t want;
    if (rst_ni) begin
      if (result_if.valid && result_if.ready) begin
        got = '{mol: result_if.molecule_echo, closed: result_if.run_closed,
                len: result_if.run_length, count: result_if.bin_count};
        results_seen++;
        if (got.closed) closed_seen++;
        if (expected_outcomes.size() == 0) begin
          log_error($sformatf("unexpected result: mol %0d closed %0d len %0d count %0d",
                              got.mol, got.closed, got.len, got.count));
        end else begin
          want = expected_outcomes.pop_front();
          if (got != want) begin
            log_error($sformatf({"mismatch: expected mol %0d closed %0d len %0d count %0d,",
                                 " got mol %0d closed %0d len %0d count %0d"},
                                want.mol, want.closed, want.len, want.count,
                                got.mol, got.closed, got.len, got.count));
          end
        end
      end
      // a long hold-off lets the pipeline fill and back up onto the sample side
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap--;
        result_if.ready <= 1'b0;
      end else if (bursty_take && !calm && $urandom_range(0, 9) == 0) begin
        take_gap = $urandom_range(0, 15);
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_sample(int mol, int size, bit eor, int repeats = 1);
    repeat (repeats) pending_samples.push_back('{mol: MOL_W'(mol), size: SIZE_W'(size),
                                                eor: eor});
  endtask

  // wait until every sample is taken and every result has come back
  task automatic wait_drained();
    while (pending_samples.size() != 0 || sample_busy || expected_outcomes.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, int unsigned value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value[CFG_W-1:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
    // the shadow keeps only the bits the register holds
    if (idx == REG_MIN_CLUSTER) begin
      min_size_q = value[SIZE_W-1:0];
    end else begin
      max_run_q = value[LEN_W-1:0];
    end
  endtask

  // random samples mostly over a small pool of molecules so that runs build up and bins repeat;
  // close_pct sets how often a sample ends its molecule's run
  task automatic queue_random_samples(int n, int close_pct);
    int mol;
    int size;
    int pick;
    int pool[8];
    bit eor;
    pool[0] = 0;
    pool[1] = 255;
    for (int i = 2; i < 8; i++) pool[i] = $urandom_range(0, 255);
    for (int i = 0; i < n; i++) begin
      mol  = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 7)] : $urandom_range(0, 255);
      pick = $urandom_range(0, 99);
      eor  = 1'b0;
      if (pick < close_pct / 3) begin
        // end of record with any size at all
        eor  = 1'b1;
        size = $urandom_range(0, 511);
      end else if (pick < close_pct && min_size_q != 0) begin
        size = $urandom_range(0, min_size_q - 1);
      end else if ($urandom_range(0, 4) == 0) begin
        size = min_size_q;
      end else begin
        size = $urandom_range(min_size_q, 511);
      end
      push_sample(mol, size, eor);
    end
  endtask

  initial begin
    int unsigned min_set[6];
    int unsigned max_set[6];
    int          close_set[6];
    min_set   = '{1, 3, 200, 0, 256, 0};
    max_set   = '{1024, 5, 2, 17, 1, 0};
    close_set = '{10, 30, 25, 8, 40, 0};
    for (int i = 0; i < NumMoleculesDef; i++) run_count[i] = '0;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_MIN_CLUSTER;
    cfg_wdata = '0;
    sample_if.valid = 1'b0;
    sample_if.molecule_index = '0;
    sample_if.cluster_size = '0;
    sample_if.end_of_record = 1'b0;
    result_if.ready = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: plain runs, end of record closing and an empty close
    push_sample(0, 1, 0, 3);
    push_sample(0, 0, 0);
    push_sample(255, 256, 0, 2);
    push_sample(255, 256, 1);
    push_sample(255, 256, 1);
    push_sample(7, 0, 0);
    push_sample(0, 511, 0);
    push_sample(0, 1, 1);
    wait_drained();

    // zero minimum extends on any size; zero maximum bins everything as length 1
    write_reg(REG_MIN_CLUSTER, 0);
    write_reg(REG_MAX_RUN, 0);
    push_sample(10, 0, 0, 3);
    push_sample(10, 0, 1);
    push_sample(11, 0, 0, 2);
    wait_drained();

    // top register values: only size 511 reaches the minimum, maximum above the bin count
    write_reg(REG_MIN_CLUSTER, 511);
    write_reg(REG_MAX_RUN, 2047);
    push_sample(11, 256, 0);
    push_sample(20, 256, 0);
    push_sample(20, 511, 0);
    push_sample(20, 0, 1);
    wait_drained();

    // random phases across several settings; the last one is fully random
    min_set[5]   = $urandom_range(0, 511);
    max_set[5]   = $urandom_range(0, 2047);
    close_set[5] = $urandom_range(5, 40);
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_MIN_CLUSTER, min_set[p]);
      write_reg(REG_MAX_RUN, max_set[p]);
      bursty_send = $urandom_range(0, 2) != 0;
      bursty_take = $urandom_range(0, 2) != 0;
      queue_random_samples(170, close_set[p]);
      if (p == 1) begin
        repeat (20) @(posedge clk_i);
        hold_token++;
      end
      wait_drained();
    end

    // last part at full rate: one long unbroken run, then some random traffic
    calm = 1'b1;
    write_reg(REG_MIN_CLUSTER, 1);
    write_reg(REG_MAX_RUN, 1024);
    push_sample(42, 1, 0, 60);
    push_sample(42, 256, 1);
    queue_random_samples(50, 15);
    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("samples %0d, results %0d, runs closed %0d, clamped %0d, at counter ceiling %0d",
             samples_taken, results_seen, closed_seen, clamped_runs, saturated_hits);
    $display("register settings covered both extremes of both registers; mismatches %0d",
             errors);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/pcrlh_pkg.sv
rtl/core/pcrlh_if.sv
rtl/core/pcrlh_ram.sv
rtl/core/pcrlh_run_stage.sv
rtl/core/pcrlh_bin_stage.sv
rtl/core/per_channel_run_length_histogram_unit.sv
tb/testbench.sv
